@@ hw/rtl/lpht_pkg.sv @@
package lpht_pkg;

    localparam int TABLE_SLOTS = 4096;
    localparam int PROBE_COUNT = 4;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int PROBE_W     = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
    localparam int MASK_W      = 12;
    localparam int ROW_W       = 128;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] REG_INDEX_MASK = 2'd0;
    localparam logic [1:0] REG_PV_TYPE    = 2'd1;

    // one classified command, as handed from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] data;
        logic        new_pv;
    } t_job;

    typedef struct packed {
        logic        hit;
        logic [7:0]  depth;
        logic [31:0] score;
        logic [15:0] move;
        logic [1:0]  kind;
    } t_result;

endpackage

@@ hw/rtl/lpht_ram.sv @@
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lpht_front.sv @@
module lpht_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_cmd,
    input  logic [63:0]         i_key,
    input  logic signed [7:0]   i_search_depth,
    input  logic signed [31:0]  i_score,
    input  logic [15:0]         i_best_move,
    input  logic [1:0]          i_kind,
    input  logic [1:0]          i_pv_type_code,
    output logic                o_job_valid,
    input  logic                i_job_take,
    output lpht_pkg::t_job      o_job
);

    lpht_pkg::t_job r_q [lpht_pkg::QUEUE_DEPTH];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    lpht_pkg::t_job w_job;
    logic w_push, w_pop;

    always_comb begin
        w_job.cmd    = i_cmd;
        w_job.key    = i_key;
        w_job.data   = {6'd0, i_kind, i_best_move, i_search_depth, i_score};
        w_job.new_pv = (i_kind == i_pv_type_code);
    end

    assign o_stall     = (r_cnt == 2'(lpht_pkg::QUEUE_DEPTH));
    assign w_push      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

@@ hw/rtl/lpht_back.sv @@
module lpht_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_take,
    input  lpht_pkg::t_job                i_job,
    input  logic [lpht_pkg::MASK_W-1:0]   i_index_mask,
    input  logic [1:0]                    i_pv_type_code,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output lpht_pkg::t_result             o_res
);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_CLEAR = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    lpht_pkg::t_job r_job;
    logic [lpht_pkg::SLOT_W-1:0]  r_addr;
    logic [lpht_pkg::PROBE_W:0]   r_probe;
    logic [lpht_pkg::SLOT_W:0]    r_sweep;
    lpht_pkg::t_result r_res;
    logic r_res_valid;

    logic                          w_we;
    logic [lpht_pkg::SLOT_W-1:0]   w_waddr, w_raddr;
    logic [lpht_pkg::ROW_W-1:0]    w_wdata, w_rdata;
    logic [63:0] w_d, w_c;
    logic w_verify, w_ok, w_last;
    logic [lpht_pkg::SLOT_W-1:0] w_next;
    logic [lpht_pkg::SLOT_W-1:0] w_slot;

    lpht_ram #(.WIDTH(lpht_pkg::ROW_W), .DEPTH(lpht_pkg::TABLE_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // r_addr holds key + probe (unmasked); the mask is applied per probe
    assign w_slot   = r_addr & i_index_mask[lpht_pkg::SLOT_W-1:0];
    assign w_d      = w_rdata[63:0];
    assign w_c      = w_rdata[127:64];
    assign w_verify = ((w_d ^ w_c) == r_job.key);
    assign w_ok     = !(!r_job.new_pv && (w_d[63:56] == {6'd0, i_pv_type_code}))
                      && !($signed(r_job.data[39:32]) < $signed(w_d[39:32]));
    assign w_last   = (r_probe == (lpht_pkg::PROBE_W+1)'(lpht_pkg::PROBE_COUNT - 1));
    assign w_next   = r_addr + 1'b1;
    assign w_raddr  = w_slot;

    assign o_job_take  = (r_state == S_IDLE) && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_slot;
        w_wdata = {r_job.key ^ r_job.data, r_job.data};
        n_state = r_state;
        unique case (r_state)
            S_INIT, S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_sweep[lpht_pkg::SLOT_W-1:0];
                w_wdata = '0;
                if (r_sweep == (lpht_pkg::SLOT_W+1)'(lpht_pkg::TABLE_SLOTS - 1)) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_OUT;
                end
            end
            S_IDLE: begin
                if (o_job_take && i_job_valid) begin
                    if (i_job.cmd == lpht_pkg::CMD_LOOKUP || i_job.cmd == lpht_pkg::CMD_STORE)
                        n_state = S_READ;
                    else if (i_job.cmd == lpht_pkg::CMD_CLEAR)
                        n_state = S_CLEAR;
                    else
                        n_state = S_OUT;
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (r_job.cmd == lpht_pkg::CMD_STORE && w_ok) begin
                    w_we    = 1'b1;
                    n_state = S_OUT;
                end else if (r_job.cmd == lpht_pkg::CMD_LOOKUP && w_verify) begin
                    n_state = S_OUT;
                end else if (w_last) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_res_valid <= 1'b0;
            r_probe     <= '0;
        end else begin
            r_state <= n_state;
            if (r_res_valid && !i_res_stall) r_res_valid <= 1'b0;
            if (r_state == S_OUT) r_res_valid <= 1'b1;
            if (r_state == S_INIT || r_state == S_CLEAR)
                r_sweep <= r_sweep + 1'b1;
            else
                r_sweep <= '0;
            // load a new job only on take, so a held result beat stays put
            if (r_state == S_IDLE && o_job_take && i_job_valid) begin
                r_probe <= '0;
                r_job   <= i_job;
                r_addr  <= i_job.key[lpht_pkg::SLOT_W-1:0];
                r_res   <= '0;
            end
            if (r_state == S_EVAL) begin
                r_probe <= r_probe + 1'b1;
                if (n_state == S_READ) r_addr <= w_next;
                if (r_job.cmd == lpht_pkg::CMD_STORE && w_ok) begin
                    r_res.hit <= 1'b1;
                end else if (r_job.cmd == lpht_pkg::CMD_LOOKUP && w_verify) begin
                    r_res.hit   <= 1'b1;
                    r_res.depth <= w_d[39:32];
                    r_res.score <= w_d[31:0];
                    r_res.move  <= w_d[55:40];
                    r_res.kind  <= w_d[57:56];
                end
            end
        end
    end

endmodule

@@ hw/rtl/lockless_probe_hash_table.sv @@
// Probe hash table with XOR-verified slots (key ^ data stored beside data).
// Lookup and store walk up to PROBE_COUNT slots from (key + i) & index_mask,
// one slot at a time through a single registered-read memory port: a taken
// job goes from S_IDLE through S_READ and S_EVAL for each probed slot to
// S_OUT, which raises the result beat; an unused command goes from S_IDLE
// directly to S_OUT. A clear sweeps the table one row a cycle; after reset
// the same clearing pass runs before the first job is taken. The back end
// takes its next job only after its result beat leaves, so a stalled result
// holds up the probe engine. A two-entry queue decouples input acceptance
// from the probe engine, and the result register holds a beat while the
// consumer stalls. For store, o_hit is 1 if the entry was written; other
// result fields are zero except on lookup hit.
module lockless_probe_hash_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [63:0]        i_key,
    input  logic signed [7:0]  i_search_depth,
    input  logic signed [31:0] i_score,
    input  logic [15:0]        i_best_move,
    input  logic [1:0]         i_kind,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic signed [7:0]  o_found_depth,
    output logic signed [31:0] o_found_score,
    output logic [15:0]        o_found_move,
    output logic [1:0]         o_found_kind,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic REG_SEL_MASK = lpht_pkg::REG_INDEX_MASK[0];

    logic [lpht_pkg::MASK_W-1:0] r_index_mask;
    logic [1:0]                  r_pv_type_code;
    logic                        w_job_valid, w_job_take;
    lpht_pkg::t_job              w_job;
    lpht_pkg::t_result           w_res;

    assign pready = 1'b1;

    // register writes on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_mask   <= 12'hFFF;
            r_pv_type_code <= 2'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SEL_MASK: r_index_mask   <= pwdata[11:0];
                default:      r_pv_type_code <= pwdata[1:0];
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SEL_MASK: prdata = {20'd0, r_index_mask};
            default:      prdata = {30'd0, r_pv_type_code};
        endcase
    end

    lpht_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_search_depth (i_search_depth),
        .i_score        (i_score),
        .i_best_move    (i_best_move),
        .i_kind         (i_kind),
        .i_pv_type_code (r_pv_type_code),
        .o_job_valid    (w_job_valid),
        .i_job_take     (w_job_take),
        .o_job          (w_job)
    );

    lpht_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_job_valid),
        .o_job_take     (w_job_take),
        .i_job          (w_job),
        .i_index_mask   (r_index_mask),
        .i_pv_type_code (r_pv_type_code),
        .o_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .o_res          (w_res)
    );

    assign o_hit         = w_res.hit;
    assign o_found_depth = w_res.depth;
    assign o_found_score = w_res.score;
    assign o_found_move  = w_res.move;
    assign o_found_kind  = w_res.kind;

endmodule

@@ hw/rtl/lpht_checker.sv @@
module lpht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_hit,
    input logic [7:0] o_found_depth,
    input logic       pready
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit)) else $error("result beat dropped");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_found_depth == 8'd0) else $error("miss with data");

    a_ready: assert property (@(posedge i_clk) pready) else $error("pready low");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result after reset");

endmodule

bind lockless_probe_hash_table lpht_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_hit         (o_hit),
    .o_found_depth (o_found_depth),
    .pready        (pready)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

    // input beat as queued for the driver
    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [7:0]  depth;
        logic [31:0] score;
        logic [15:0] move;
        logic [1:0]  kind;
    } t_probe_req;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_cmd;
    logic [63:0]        i_key;
    logic signed [7:0]  i_search_depth;
    logic signed [31:0] i_score;
    logic [15:0]        i_best_move;
    logic [1:0]         i_kind;
    logic               o_valid;
    logic               i_stall;
    logic               o_hit;
    logic signed [7:0]  o_found_depth;
    logic signed [31:0] o_found_score;
    logic [15:0]        o_found_move;
    logic [1:0]         o_found_kind;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    lockless_probe_hash_table uut (.*);

    // shadow table and registers
    logic [63:0] shadow_data [lpht_pkg::TABLE_SLOTS];
    logic [63:0] shadow_check[lpht_pkg::TABLE_SLOTS];
    logic [11:0] mask_q;
    logic [1:0]  pv_q;

    t_probe_req          pending_q[$];
    lpht_pkg::t_result   expected_q[$];
    int         error_count;
    bit         quiet_tail;   // no idling in the final stretch
    int         src_gap, sink_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // fixed watchdog: clear sweeps plus worst-case stalls, several times over
    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    // golden hash-table update; returns the one result beat for a request
    function automatic lpht_pkg::t_result table_predict(t_probe_req r);
        lpht_pkg::t_result res;
        logic [63:0] d, nd;
        logic [11:0] s;
        res = '0;
        case (r.cmd)
            lpht_pkg::CMD_LOOKUP: begin
                for (int i = 0; i < lpht_pkg::PROBE_COUNT; i++) begin
                    s = 12'(r.key + 64'(i)) & mask_q;
                    d = shadow_data[s];
                    if (!res.hit && ((d ^ shadow_check[s]) == r.key)) begin
                        res.hit   = 1'b1;
                        res.depth = d[39:32];
                        res.score = d[31:0];
                        res.move  = d[55:40];
                        res.kind  = d[57:56];
                    end
                end
            end
            lpht_pkg::CMD_STORE: begin
                nd = {6'd0, r.kind, r.move, r.depth, r.score};
                for (int i = 0; i < lpht_pkg::PROBE_COUNT; i++) begin
                    s = 12'(r.key + 64'(i)) & mask_q;
                    d = shadow_data[s];
                    // protected PV slot only yields to another PV entry
                    if (!res.hit && !(r.kind != pv_q && d[63:56] == {6'd0, pv_q})
                        && !($signed(r.depth) < $signed(d[39:32]))) begin
                        shadow_data[s]  = nd;
                        shadow_check[s] = r.key ^ nd;
                        res.hit = 1'b1;
                    end
                end
            end
            lpht_pkg::CMD_CLEAR: begin
                for (int i = 0; i < lpht_pkg::TABLE_SLOTS; i++) begin
                    shadow_data[i]  = '0;
                    shadow_check[i] = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // driver: pops pending beats, holds payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_q.push_back(table_predict(
                    {i_cmd, i_key, i_search_depth, i_score, i_best_move, i_kind}));
            end
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    t_probe_req r;
                    r = pending_q.pop_front();
                    i_valid        <= 1'b1;
                    i_cmd          <= r.cmd;
                    i_key          <= r.key;
                    i_search_depth <= r.depth;
                    i_score        <= r.score;
                    i_best_move    <= r.move;
                    i_kind         <= r.kind;
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        src_gap <= $urandom_range(1, 10);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare every result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_count++;
                end else begin
                    lpht_pkg::t_result e;
                    e = expected_q.pop_front();
                    if (o_hit !== e.hit) begin
                        $error("hit exp %0d got %0d", e.hit, o_hit); error_count++;
                    end
                    if (o_found_depth !== e.depth) begin
                        $error("found_depth exp %0d got %0d", $signed(e.depth),
                               o_found_depth); error_count++;
                    end
                    if (o_found_score !== e.score) begin
                        $error("found_score exp %0d got %0d", $signed(e.score),
                               o_found_score); error_count++;
                    end
                    if (o_found_move !== e.move) begin
                        $error("found_move exp %0h got %0h", e.move, o_found_move);
                        error_count++;
                    end
                    if (o_found_kind !== e.kind) begin
                        $error("found_kind exp %0d got %0d", e.kind, o_found_kind);
                        error_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_stall  <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 9);
                i_stall  <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx[0], 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == lpht_pkg::REG_INDEX_MASK) mask_q = val[11:0];
        else if (idx == lpht_pkg::REG_PV_TYPE) pv_q = val[1:0];
    endtask

    // drain pending and expected beats, then let a clear sweep finish
    task automatic wait_idle();
        while (pending_q.size() > 0 || i_valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (lpht_pkg::TABLE_SLOTS + 20) @(posedge i_clk);
    endtask

    function automatic t_probe_req make_req(logic [1:0] c, logic [63:0] k,
                                            logic [7:0] dp, logic [1:0] kd);
        t_probe_req r;
        r.cmd = c; r.key = k; r.depth = dp;
        r.score = $urandom; r.move = $urandom; r.kind = kd;
        return r;
    endfunction

    // random key drawn from a small hot set so lookups and probes collide
    function automatic logic [63:0] hot_key(int n);
        logic [63:0] k;
        k = {$urandom, $urandom};
        k[11:0] = 12'($urandom_range(0, n));
        if ($urandom_range(0, 3) == 0) k[63:12] = 52'($urandom_range(0, 3));
        return k;
    endfunction

    task automatic random_phase(int count, int hot);
        t_probe_req r;
        for (int i = 0; i < count; i++) begin
            r = make_req(2'($urandom_range(0, 1)), hot_key(hot),
                         8'($urandom), 2'($urandom));
            if ($urandom_range(0, 300) == 0) r.cmd = lpht_pkg::CMD_CLEAR;
            else if ($urandom_range(0, 60) == 0) r.cmd = 2'd3;
            pending_q.push_back(r);
        end
    endtask

    initial begin
        error_count = 0;
        quiet_tail  = 1'b0;
        mask_q = 12'hFFF;
        pv_q   = 2'd1;
        for (int i = 0; i < lpht_pkg::TABLE_SLOTS; i++) begin
            shadow_data[i] = '0; shadow_check[i] = '0;
        end
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_cmd = '0; i_key = '0; i_search_depth = '0; i_score = '0;
        i_best_move = '0; i_kind = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // post-reset clearing pass
        repeat (lpht_pkg::TABLE_SLOTS + 20) @(posedge i_clk);

        // directed: key zero on empty table, extremes, PV protection, unused command, clear
        pending_q.push_back(make_req(lpht_pkg::CMD_LOOKUP, 64'd0, 8'd0, 2'd0));
        pending_q.push_back(make_req(lpht_pkg::CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF,
                                     8'h7F, 2'd3));
        pending_q.push_back(make_req(lpht_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF,
                                     8'd0, 2'd0));
        // negative depth, dropped
        pending_q.push_back(make_req(lpht_pkg::CMD_STORE, 64'h10, 8'h80, 2'd0));
        // PV entry
        pending_q.push_back(make_req(lpht_pkg::CMD_STORE, 64'h20, 8'd5, 2'd1));
        for (int i = 0; i < 4; i++)
            pending_q.push_back(make_req(lpht_pkg::CMD_STORE, 64'h20 + 64'(i << 12),
                                         8'd9, 2'd2));
        pending_q.push_back(make_req(lpht_pkg::CMD_STORE, 64'h1020, 8'd9, 2'd1));
        pending_q.push_back(make_req(lpht_pkg::CMD_LOOKUP, 64'h20, 8'd0, 2'd0));
        pending_q.push_back(make_req(lpht_pkg::CMD_LOOKUP, 64'h1020, 8'd0, 2'd0));
        pending_q.push_back(make_req(2'd3, 64'h20, 8'd0, 2'd0));
        pending_q.push_back(make_req(lpht_pkg::CMD_CLEAR, 64'd0, 8'd0, 2'd0));
        pending_q.push_back(make_req(lpht_pkg::CMD_LOOKUP, 64'h20, 8'd0, 2'd0));
        pending_q.push_back(make_req(lpht_pkg::CMD_LOOKUP, 64'h0, 8'd0, 2'd0));
        wait_idle();

        random_phase(500, 63);
        wait_idle();
        reg_write(lpht_pkg::REG_INDEX_MASK, 32'd0);      // single slot
        reg_write(lpht_pkg::REG_PV_TYPE, 32'd3);
        random_phase(300, 7);
        wait_idle();
        reg_write(lpht_pkg::REG_INDEX_MASK, 32'd15);
        reg_write(lpht_pkg::REG_PV_TYPE, 32'd0);
        random_phase(400, 31);
        wait_idle();
        reg_write(lpht_pkg::REG_INDEX_MASK, 32'hFFF);
        reg_write(lpht_pkg::REG_PV_TYPE, 32'd2);
        random_phase(400, 4095);
        wait_idle();
        quiet_tail = 1'b1;
        reg_write(lpht_pkg::REG_PV_TYPE, 32'd1);
        random_phase(300, 127);
        wait_idle();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
